[src/wfl_pkg.sv]
package wfl_pkg;

  localparam int NumMotorsDefault = 4;
  localparam int MaxMotors        = 4;
  localparam int MotorIdxW        = 2;
  localparam int SpeedW           = 16;
  localparam int MagW             = 15;
  localparam int TimeW            = 32;
  localparam int CntW             = 8;
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 32;

  typedef enum logic [1:0] {
    CmdReset  = 2'd0,
    CmdDetect = 2'd1,
    CmdCheck  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinTarget  = 3'd0,
    CfgMinMoving  = 3'd1,
    CfgTimeout    = 3'd2,
    CfgMissLimit  = 3'd3,
    CfgEnableMask = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic [MotorIdxW-1:0]       motor_index;
    logic [TimeW-1:0]           now_ms;
    logic [MaxMotors*SpeedW-1:0] requested_speeds;
    logic [MaxMotors*SpeedW-1:0] measured_speeds;
    logic [MaxMotors-1:0]       speed_valid_mask;
    logic [MaxMotors-1:0]       drive_running_mask;
    logic signed [SpeedW-1:0]   target_speed;
    logic signed [SpeedW-1:0]   actual_speed;
    logic                       encoder_ok;
  } in_t;

  typedef struct packed {
    logic                 fault_found;
    logic                 feedback_usable;
    logic [MaxMotors-1:0] lost_flags;
  } out_t;

  typedef struct packed {
    logic [MagW-1:0]      min_target;
    logic [MagW-1:0]      min_moving;
    logic [TimeW-1:0]     timeout;
    logic [CntW-1:0]      miss_limit;
    logic [MaxMotors-1:0] enable_mask;
  } cfg_t;

  // what one lane decides for its motor during a detect scan
  typedef struct packed {
    logic stop;
    logic clr_active;
    logic start;
  } lane_res_t;

  // magnitude of a signed speed, -32768 saturating to 32767
  function automatic logic [MagW-1:0] sat_abs(input logic [SpeedW-1:0] x);
    logic [SpeedW-1:0] neg;
    neg = SpeedW'(~x + SpeedW'(1));
    if (!x[SpeedW-1]) begin
      return x[MagW-1:0];
    end else if (x == {1'b1, {(SpeedW-1){1'b0}}}) begin
      return {MagW{1'b1}};
    end else begin
      return neg[MagW-1:0];
    end
  endfunction

  function automatic logic no_motion(input logic [MagW-1:0] abs_t,
                                     input logic [MagW-1:0] abs_a,
                                     input cfg_t            cfg);
    return (abs_t < cfg.min_target) || (abs_a >= cfg.min_moving);
  endfunction

endpackage

[src/wfl_lane.sv]
module wfl_lane (
  input  logic                       enable_i,
  input  logic                       speed_valid_i,
  input  logic                       running_i,
  input  logic [wfl_pkg::SpeedW-1:0] requested_i,
  input  logic [wfl_pkg::SpeedW-1:0] measured_i,
  input  logic [wfl_pkg::TimeW-1:0]  now_i,
  input  logic [wfl_pkg::TimeW-1:0]  still_since_i,
  input  logic                       still_active_i,
  input  wfl_pkg::cfg_t              cfg_i,
  output wfl_pkg::lane_res_t         res_o
);

  logic [wfl_pkg::TimeW-1:0] elapsed;
  logic                      idle;

  assign elapsed = now_i - still_since_i;
  assign idle    = wfl_pkg::no_motion(wfl_pkg::sat_abs(requested_i),
                                      wfl_pkg::sat_abs(measured_i), cfg_i);

  always_comb begin
    res_o = '0;
    if (!enable_i) begin
      res_o.clr_active = 1'b1;
    end else if (!speed_valid_i) begin
      res_o.stop = 1'b1;
    end else if (idle || !running_i) begin
      res_o.clr_active = 1'b1;
    end else if (!still_active_i) begin
      // first still sample only arms the timer
      res_o.start = 1'b1;
    end else if (elapsed >= cfg_i.timeout) begin
      res_o.stop = 1'b1;
    end
  end

endmodule

[src/wfl_merge.sv]
module wfl_merge #(
  parameter int NUM_MOTORS = wfl_pkg::NumMotorsDefault
) (
  input  logic [NUM_MOTORS-1:0] stop_i,
  output logic [NUM_MOTORS-1:0] reached_o,
  output logic                  fault_o
);

  // a lane is reached only when no lower lane stopped the scan
  always_comb begin
    reached_o[0] = 1'b1;
    for (int i = 1; i < NUM_MOTORS; i++) begin
      reached_o[i] = reached_o[i-1] & ~stop_i[i-1];
    end
    fault_o = |(stop_i & reached_o);
  end

endmodule

[src/wheel_feedback_loss_monitor.sv]
// a result is registered as its item is accepted, in the output register or the skid
// one item per cycle while the skid register is empty; lanes and merge are combinational
// an output register plus one skid register let one more item in while a result waits
// reset: counters, timers and lost flags cleared, configuration to reset values
// (thresholds 0, all motors enabled), no result pending
module wheel_feedback_loss_monitor #(
  parameter int NUM_MOTORS = wfl_pkg::NumMotorsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wfl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wfl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  wfl_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output wfl_pkg::out_t                out_data_o
);

  localparam int MM = wfl_pkg::MaxMotors;

  wfl_pkg::cfg_t cfg_q;

  logic [wfl_pkg::CntW-1:0]  miss_q [MM];
  logic [wfl_pkg::CntW-1:0]  miss_d [MM];
  logic [wfl_pkg::TimeW-1:0] since_q [MM];
  logic [wfl_pkg::TimeW-1:0] since_d [MM];
  logic [MM-1:0]             active_q, active_d;
  logic [MM-1:0]             lost_q, lost_d;

  wfl_pkg::out_t out_q, skid_q, res;
  logic          out_valid_q, skid_valid_q;
  logic          in_acc, out_acc;

  wfl_pkg::lane_res_t    lane_res [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] stops, reached;
  logic                  fault;

  // check path
  logic [wfl_pkg::CntW-1:0] cnt, cnt_inc;
  logic                     idx_ok, chk_idle;

  assign in_ready_o  = ~skid_valid_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_q & out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
    wfl_lane u_lane (
      .enable_i       (cfg_q.enable_mask[g]),
      .speed_valid_i  (in_data_i.speed_valid_mask[g]),
      .running_i      (in_data_i.drive_running_mask[g]),
      .requested_i    (in_data_i.requested_speeds[g*wfl_pkg::SpeedW +: wfl_pkg::SpeedW]),
      .measured_i     (in_data_i.measured_speeds[g*wfl_pkg::SpeedW +: wfl_pkg::SpeedW]),
      .now_i          (in_data_i.now_ms),
      .still_since_i  (since_q[g]),
      .still_active_i (active_q[g]),
      .cfg_i          (cfg_q),
      .res_o          (lane_res[g])
    );
    assign stops[g] = lane_res[g].stop;
  end

  wfl_merge #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_merge (
    .stop_i    (stops),
    .reached_o (reached),
    .fault_o   (fault)
  );

  assign idx_ok   = int'(in_data_i.motor_index) < NUM_MOTORS;
  assign cnt      = miss_q[in_data_i.motor_index];
  assign cnt_inc  = (cnt < cfg_q.miss_limit) ? wfl_pkg::CntW'(cnt + 1'b1) : cnt;
  assign chk_idle = wfl_pkg::no_motion(wfl_pkg::sat_abs(in_data_i.target_speed),
                                       wfl_pkg::sat_abs(in_data_i.actual_speed), cfg_q);

  always_comb begin
    miss_d   = miss_q;
    since_d  = since_q;
    active_d = active_q;
    lost_d   = lost_q;
    res      = '0;
    case (in_data_i.cmd)
      wfl_pkg::CmdReset: begin
        for (int i = 0; i < MM; i++) begin
          miss_d[i]  = '0;
          since_d[i] = '0;
        end
        active_d = '0;
        lost_d   = '0;
      end
      wfl_pkg::CmdDetect: begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          if (reached[i]) begin
            if (lane_res[i].stop)       lost_d[i]   = 1'b1;
            if (lane_res[i].clr_active) active_d[i] = 1'b0;
            if (lane_res[i].start) begin
              active_d[i] = 1'b1;
              since_d[i]  = in_data_i.now_ms;
            end
          end
        end
        res.fault_found = fault;
      end
      wfl_pkg::CmdCheck: begin
        if (idx_ok) begin
          lost_d[in_data_i.motor_index] = 1'b0;
          if (!in_data_i.encoder_ok) begin
            miss_d[in_data_i.motor_index] = cfg_q.miss_limit;
            lost_d[in_data_i.motor_index] = 1'b1;
          end else if (chk_idle) begin
            miss_d[in_data_i.motor_index] = '0;
            res.feedback_usable           = 1'b1;
          end else begin
            miss_d[in_data_i.motor_index] = cnt_inc;
            if (cnt_inc >= cfg_q.miss_limit) begin
              lost_d[in_data_i.motor_index] = 1'b1;
            end else begin
              res.feedback_usable = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.lost_flags = lost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_target: '0, min_moving: '0, timeout: '0, miss_limit: '0,
                 enable_mask: {MM{1'b1}}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wfl_pkg::CfgMinTarget:  cfg_q.min_target  <= cfg_data_i[wfl_pkg::MagW-1:0];
        wfl_pkg::CfgMinMoving:  cfg_q.min_moving  <= cfg_data_i[wfl_pkg::MagW-1:0];
        wfl_pkg::CfgTimeout:    cfg_q.timeout     <= cfg_data_i[wfl_pkg::TimeW-1:0];
        wfl_pkg::CfgMissLimit:  cfg_q.miss_limit  <= cfg_data_i[wfl_pkg::CntW-1:0];
        wfl_pkg::CfgEnableMask: cfg_q.enable_mask <= cfg_data_i[MM-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MM; i++) begin
        miss_q[i]  <= '0;
        since_q[i] <= '0;
      end
      active_q <= '0;
      lost_q   <= '0;
    end else if (in_acc) begin
      miss_q   <= miss_d;
      since_q  <= since_d;
      active_q <= active_d;
      lost_q   <= lost_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      if (!out_valid_q || out_acc) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_acc) begin
      out_valid_q  <= skid_valid_q;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!out_valid_q || out_acc) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_acc && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  // skid holds an item only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid item without output item");

  // the scan stops at one motor at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(stops & reached))
    else $error("more than one lane ended the scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.cmd == wfl_pkg::CmdReset |=> lost_q == '0)
    else $error("lost flags survived a reset item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.fault_found && out_q.lost_flags == '0))
    else $error("fault reported without a lost flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.fault_found && out_q.feedback_usable))
    else $error("detect and check results both set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.cmd == wfl_pkg::CmdCheck && !in_data_i.encoder_ok && idx_ok
    |=> lost_q[$past(in_data_i.motor_index)])
    else $error("bad encoder not flagged lost");

endmodule
